// File: rtl/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
// Included by the top level; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be true outside reset.
`define SPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int KIND_W        = 2;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;
    localparam int CAP_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_SORTED = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_PEEK   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: rtl/spq_ram.sv
// Entry store: one write port, one read port, registered read data.
// Depends on spq_pkg for the word width.
`default_nettype none

module spq_ram #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  wire logic [spq_pkg::VALUE_W-1:0] wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic      [spq_pkg::VALUE_W-1:0] rd_data
);

    logic [spq_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [spq_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Bounded queue of signed 32-bit words, head at entry 0. Kinds: append at
// tail, sorted insert (after every entry >= value), remove head, peek head;
// each transfer in yields one result transfer out. One item is worked at a
// time through the entry RAM and one signed comparator, one RAM access per
// cycle with the read data registered; each entry touched is read, then
// compared or written. Refused inserts and remove/peek when empty go straight
// to the result; remove moves each later entry one place toward the head;
// sorted insert scans from the head, then shifts entries toward the tail.
// A new item is taken while the previous result still waits at the output.
// Depends on spq_pkg, spq_ram and sorted_priority_queue_assert.svh.
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_wr_en,
    input  wire logic        [spq_pkg::CAP_W-1:0]   cfg_wr_data,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic        [spq_pkg::KIND_W-1:0]  kind,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] value,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic             [spq_pkg::STATUS_W-1:0] status,
    output logic signed      [spq_pkg::VALUE_W-1:0] head_value,
    output logic             [spq_pkg::COUNT_W-1:0] fill_count
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = spq_pkg::COUNT_W;
    localparam int CNT_MAX = (1 << CW) - 1;
    localparam int LIM_INT = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

    localparam logic [CW-1:0] DEPTH_LIM = CW'(LIM_INT);
    localparam logic [CW-1:0] ONE       = CW'(1);
    localparam logic [CW-1:0] ZERO      = '0;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_SCAN_RD  = 11'b000_0000_0010,
        ST_SCAN_CMP = 11'b000_0000_0100,
        ST_SHIFT_RD = 11'b000_0000_1000,
        ST_SHIFT_WR = 11'b000_0001_0000,
        ST_PUT      = 11'b000_0010_0000,
        ST_HEAD_RD  = 11'b000_0100_0000,
        ST_HEAD_CMP = 11'b000_1000_0000,
        ST_DRAIN_RD = 11'b001_0000_0000,
        ST_DRAIN_WR = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } state_t;

    // control state
    state_t                     state_reg,     state_next;
    logic [CW-1:0]              count_reg,     count_next;
    logic [spq_pkg::CAP_W-1:0]  capacity_reg;
    logic                       out_valid_reg, out_valid_next;

    // working registers
    logic [CW-1:0]                ptr_reg,    ptr_next;
    logic [CW-1:0]                pos_reg,    pos_next;
    spq_pkg::kind_t               kind_reg,   kind_next;
    logic [spq_pkg::VALUE_W-1:0]  value_reg,  value_next;
    spq_pkg::status_t             result_reg, result_next;
    logic [spq_pkg::VALUE_W-1:0]  head_reg,   head_next;

    // output payload
    logic [spq_pkg::STATUS_W-1:0] out_status_reg;
    logic [spq_pkg::VALUE_W-1:0]  out_head_reg;
    logic [CW-1:0]                out_count_reg;
    logic                         out_load;

    // RAM port
    logic                         mem_we;
    logic [CW-1:0]                mem_wptr;
    logic [spq_pkg::VALUE_W-1:0]  mem_wdata;
    logic [CW-1:0]                mem_rptr;
    logic [spq_pkg::VALUE_W-1:0]  mem_rdata;

    logic full;
    logic entry_less;

    assign full       = (count_reg >= capacity_reg) || (count_reg >= DEPTH_LIM);
    assign entry_less = $signed(mem_rdata) < $signed(value_reg);

    spq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (AW'(mem_wptr)),
        .wr_data (mem_wdata),
        .rd_addr (AW'(mem_rptr)),
        .rd_data (mem_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        result_next = result_reg;
        head_next   = head_reg;
        mem_we      = 1'b0;
        mem_wptr    = ptr_reg;
        mem_wdata   = mem_rdata;
        mem_rptr    = ZERO;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = spq_pkg::kind_t'(kind);
                    value_next  = value;
                    result_next = spq_pkg::STATUS_OK;
                    head_next   = '0;
                    case (spq_pkg::kind_t'(kind))
                        spq_pkg::KIND_APPEND:
                        begin
                            if (full)
                            begin
                                result_next = spq_pkg::STATUS_FULL;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                state_next = ST_PUT;
                            end
                        end
                        spq_pkg::KIND_SORTED:
                        begin
                            if (full)
                            begin
                                result_next = spq_pkg::STATUS_FULL;
                                state_next  = ST_DONE;
                            end
                            else if (count_reg == ZERO)
                            begin
                                pos_next   = ZERO;
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                ptr_next   = ZERO;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            if (count_reg == ZERO)
                            begin
                                result_next = spq_pkg::STATUS_EMPTY;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_HEAD_RD;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN_RD:
            begin
                mem_rptr   = ptr_reg;
                state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                // first entry below the new value marks the slot
                if (entry_less)
                begin
                    pos_next   = ptr_reg;
                    ptr_next   = count_reg;
                    state_next = ST_SHIFT_RD;
                end
                else if (ptr_reg + ONE == count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = ST_PUT;
                end
                else
                begin
                    ptr_next   = ptr_reg + ONE;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SHIFT_RD:
            begin
                mem_rptr   = ptr_reg - ONE;
                state_next = ST_SHIFT_WR;
            end

            ST_SHIFT_WR:
            begin
                // move toward the tail, working down from the end
                mem_we   = 1'b1;
                mem_wptr = ptr_reg;
                ptr_next = ptr_reg - ONE;
                if (ptr_reg - ONE == pos_reg)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end

            ST_PUT:
            begin
                mem_we     = 1'b1;
                mem_wptr   = pos_reg;
                mem_wdata  = value_reg;
                count_next = count_reg + ONE;
                state_next = ST_DONE;
            end

            ST_HEAD_RD:
            begin
                mem_rptr   = ZERO;
                state_next = ST_HEAD_CMP;
            end

            ST_HEAD_CMP:
            begin
                head_next = mem_rdata;
                if (kind_reg == spq_pkg::KIND_PEEK)
                begin
                    state_next = ST_DONE;
                end
                else if (count_reg == ONE)
                begin
                    count_next = ZERO;
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next   = ZERO;
                    state_next = ST_DRAIN_RD;
                end
            end

            ST_DRAIN_RD:
            begin
                mem_rptr   = ptr_reg + ONE;
                state_next = ST_DRAIN_WR;
            end

            ST_DRAIN_WR:
            begin
                mem_we   = 1'b1;
                mem_wptr = ptr_reg;
                if (ptr_reg + ONE == count_reg - ONE)
                begin
                    count_next = count_reg - ONE;
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next   = ptr_reg + ONE;
                    state_next = ST_DRAIN_RD;
                end
            end

            ST_DONE:
            begin
                // hold here only while the output still has an untaken result
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            capacity_reg  <= spq_pkg::CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        result_reg <= result_next;
        head_reg   <= head_next;
        if (out_load)
        begin
            out_status_reg <= result_reg;
            out_head_reg   <= head_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign head_value = out_head_reg;
    assign fill_count = out_count_reg;

`include "sorted_priority_queue_assert.svh"

    `SPQ_ASSERT_NEVER(a_count_bounded, clk, rst_n, count_reg > DEPTH_LIM, "fill above depth")
    `SPQ_ASSERT(a_write_within_fill, clk, rst_n,
        mem_we |-> (mem_wptr <= count_reg), "write past tail")
    `SPQ_ASSERT(a_idle_holds_count, clk, rst_n,
        (state_reg == ST_IDLE) |=> $stable(count_reg), "fill moved in idle")
    `SPQ_ASSERT(a_result_from_done, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE), "result outside done")

endmodule

`default_nettype wire
